// ----- rtl/tdl_pkg.sv -----
// ----------------------------------------------------------------------------
// tdl_pkg - shared types for the task delay timeout list
// operation codes, sequencer states and the sequencer/report handshake
// ----------------------------------------------------------------------------
package tdl_pkg;

  localparam int SLOT_W = 5;
  localparam int TICK_W = 32;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WAIT   = 2'd1,
    OP_CANCEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } seq_state_t;

  // sequencer to report stage
  typedef struct packed {
    logic              push;
    logic              flush;
    logic [SLOT_W-1:0] slot;
    logic              ev;
  } rpt_req_t;

  // report stage to sequencer
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
    logic pend_valid;
  } rpt_stat_t;

endpackage

// ----- rtl/tdl_ram.sv -----
// ----------------------------------------------------------------------------
// tdl_ram - countdown storage
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tdl_ram #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/tdl_rpt.sv -----
// ----------------------------------------------------------------------------
// tdl_rpt - expiry report stage
// holds the newest expiry until the next one or the end of the sweep
// decides whether it was the last of the tick, then loads the output register
// ----------------------------------------------------------------------------
module tdl_rpt (
  input  logic                      clk,
  input  logic                      rst,
  input  tdl_pkg::rpt_req_t         rpt_req,
  output tdl_pkg::rpt_stat_t        rpt_stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tdl_pkg::SLOT_W-1:0] expired_slot,
  output logic                      event_timeout,
  output logic                      last_of_tick
);
  import tdl_pkg::*;

  logic              pend_valid;
  logic [SLOT_W-1:0] pend_slot;
  logic              pend_ev;
  logic              out_free;
  logic              do_push;
  logic              do_flush;
  logic              load_out;

  assign out_free = !out_valid || out_ready;
  assign do_push  = rpt_req.push && (!pend_valid || out_free);
  assign do_flush = rpt_req.flush && pend_valid && out_free;
  assign load_out = (do_push && pend_valid) || do_flush;

  assign rpt_stat.push_ok    = !pend_valid || out_free;
  assign rpt_stat.flush_ok   = !pend_valid || out_free;
  assign rpt_stat.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (do_push) begin
        pend_valid <= 1'b1;
      end else if (do_flush) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      pend_slot <= rpt_req.slot;
      pend_ev   <= rpt_req.ev;
    end
    if (load_out) begin
      expired_slot  <= pend_slot;
      event_timeout <= pend_ev;
      last_of_tick  <= do_flush;
    end
  end

endmodule

// ----- rtl/tdl_seq.sv -----
// ----------------------------------------------------------------------------
// tdl_seq - slot sequencer with the shared decrementer
// takes wait and cancel beats directly, sweeps all slots on a tick
// ----------------------------------------------------------------------------
module tdl_seq #(
  parameter int TASK_SLOTS = 32,
  parameter int IDX_W      = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 operation,
  input  logic [tdl_pkg::SLOT_W-1:0] task_slot,
  input  logic [tdl_pkg::TICK_W-1:0] tick_count,
  input  logic                       waits_on_event,
  output logic                       ram_wr_en,
  output logic [IDX_W-1:0]           ram_wr_addr,
  output logic [tdl_pkg::TICK_W-1:0] ram_wr_data,
  output logic                       ram_rd_en,
  output logic [IDX_W-1:0]           ram_rd_addr,
  input  logic [tdl_pkg::TICK_W-1:0] ram_rd_data,
  output tdl_pkg::rpt_req_t          rpt_req,
  input  tdl_pkg::rpt_stat_t         rpt_stat
);
  import tdl_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  seq_state_t            state;
  seq_state_t            state_next;
  logic [IDX_W-1:0]      idx;
  logic [TASK_SLOTS-1:0] armed;
  logic [TASK_SLOTS-1:0] evw;
  logic                  accept;
  logic                  slot_ok;
  logic [IDX_W-1:0]      slot_idx;
  logic [TICK_W-1:0]     dec_val;
  logic                  dec_zero;
  logic                  step_ok;
  logic                  is_wait;
  logic                  is_cancel;
  logic                  is_tick;

  assign accept   = in_valid && in_ready;
  assign slot_ok  = 32'(task_slot) < TASK_SLOTS;
  assign slot_idx = IDX_W'(task_slot);

  // shared decrementer and zero check
  assign dec_val  = ram_rd_data - TICK_W'(1);
  assign dec_zero = (dec_val == '0);
  assign step_ok  = (state == S_EVAL) && (!dec_zero || rpt_stat.push_ok);

  always_comb begin
    is_wait   = 1'b0;
    is_cancel = 1'b0;
    is_tick   = 1'b0;
    unique case (op_t'(operation))
      OP_TICK:   is_tick   = 1'b1;
      OP_WAIT:   is_wait   = 1'b1;
      OP_CANCEL: is_cancel = 1'b1;
      default:   ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && is_tick) state_next = S_READ;
      end
      S_READ: begin
        if (armed[idx]) state_next = S_EVAL;
        else if (idx == LAST_IDX) state_next = S_FLUSH;
      end
      S_EVAL: begin
        if (step_ok) state_next = (idx == LAST_IDX) ? S_FLUSH : S_READ;
      end
      S_FLUSH: begin
        if (rpt_stat.flush_ok) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = (state == S_IDLE);
    ram_rd_en     = (state == S_READ) && armed[idx];
    ram_rd_addr   = idx;
    ram_wr_en     = step_ok || (accept && is_wait && slot_ok);
    ram_wr_addr   = (state == S_EVAL) ? idx : slot_idx;
    ram_wr_data   = (state == S_EVAL) ? dec_val : tick_count;
    rpt_req.push  = (state == S_EVAL) && dec_zero;
    rpt_req.flush = (state == S_FLUSH);
    rpt_req.slot  = SLOT_W'(idx);
    rpt_req.ev    = evw[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      armed <= '0;
      evw   <= '0;
    end else begin
      state <= state_next;
      if (accept && is_tick) begin
        idx <= '0;
      end else if ((state == S_READ) && !armed[idx] && (idx != LAST_IDX)) begin
        idx <= idx + IDX_W'(1);
      end else if (step_ok && (idx != LAST_IDX)) begin
        idx <= idx + IDX_W'(1);
      end
      if (accept && is_wait && slot_ok) begin
        armed[slot_idx] <= 1'b1;
        evw[slot_idx]   <= waits_on_event;
      end else if (accept && is_cancel && slot_ok) begin
        armed[slot_idx] <= 1'b0;
        evw[slot_idx]   <= 1'b0;
      end else if (step_ok && dec_zero) begin
        armed[idx] <= 1'b0;
        evw[idx]   <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/task_delay_timeout_list_top.sv -----
// ----------------------------------------------------------------------------
// task_delay_timeout_list_top - tick delay list for a task scheduler
// one 32-bit countdown per task slot, expiries reported in slot order
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one command beat: operation
//   selects tick, wait (arm task_slot with tick_count and waits_on_event)
//   or cancel (disarm task_slot). wait and cancel beats produce no output.
//   output channel (out_valid/out_ready) carries one beat per expired slot
//   of a tick, ascending slot order; last_of_tick marks the final one.
// timing:
//   wait and cancel leave the sequencer idle, so in_ready stays high.
//   a tick sweeps every slot through the single read port of the counter
//   ram and one shared decrementer: an unarmed slot passes through S_READ
//   only, an armed slot through S_READ and S_EVAL, then S_FLUSH closes.
//   in_ready stays low for the whole sweep.
// reset:
//   synchronous rst disarms every slot and empties the output stage;
//   counter contents are left as they are and only read once armed.
// stalls:
//   an expiry is held one step back so its last flag is known; with one
//   held, out_valid high and out_ready low, the next expiry or close stalls.
// ----------------------------------------------------------------------------
module task_delay_timeout_list_top #(
  parameter int TASK_SLOTS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 operation,
  input  logic [tdl_pkg::SLOT_W-1:0] task_slot,
  input  logic [tdl_pkg::TICK_W-1:0] tick_count,
  input  logic                       waits_on_event,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tdl_pkg::SLOT_W-1:0] expired_slot,
  output logic                       event_timeout,
  output logic                       last_of_tick
);
  import tdl_pkg::*;

  // slot index width, at least one bit for a single-slot build
  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [TICK_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [TICK_W-1:0] ram_rd_data;
  rpt_req_t          rpt_req;
  rpt_stat_t         rpt_stat;

  // sequencer: command decode, slot flags, sweep control, decrementer
  tdl_seq #(
    .TASK_SLOTS (TASK_SLOTS),
    .IDX_W      (IDX_W)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .task_slot      (task_slot),
    .tick_count     (tick_count),
    .waits_on_event (waits_on_event),
    .ram_wr_en      (ram_wr_en),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_en      (ram_rd_en),
    .ram_rd_addr    (ram_rd_addr),
    .ram_rd_data    (ram_rd_data),
    .rpt_req        (rpt_req),
    .rpt_stat       (rpt_stat)
  );

  // countdown storage, one entry per slot
  tdl_ram #(
    .DEPTH  (TASK_SLOTS),
    .ADDR_W (IDX_W),
    .DATA_W (TICK_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // report hold and output register
  tdl_rpt u_rpt (
    .clk           (clk),
    .rst           (rst),
    .rpt_req       (rpt_req),
    .rpt_stat      (rpt_stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .expired_slot  (expired_slot),
    .event_timeout (event_timeout),
    .last_of_tick  (last_of_tick)
  );

  // no expiry may still be held once the sweep is over
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !rpt_stat.pend_valid)
    else $error("expiry still held while idle");

  // a tick always starts a sweep
  a_tick_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_TICK)) |=> !in_ready)
    else $error("tick accepted without a sweep");

  // the counter ram is never read and written in the same cycle
  a_ram_one_access: assert property (@(posedge clk) disable iff (rst)
    !(ram_wr_en && ram_rd_en))
    else $error("counter ram read and write collide");

endmodule
